[hdl/atoi_pkg.sv]
// ----------------------------------------------------------------------------
// atoi_pkg
// Shared types, character constants and helpers for the text to integer
// parser.
// ----------------------------------------------------------------------------
package atoi_pkg;

    // width of the character position counter
    localparam int CountWidth = 16;

    // configuration register indexes
    localparam logic [1:0] RegNumberBase = 2'd0;
    localparam logic [1:0] RegSignedMode = 2'd1;
    localparam logic [1:0] RegNarrowMode = 2'd2;

    // result status codes
    localparam logic [1:0] StConverted = 2'd0;
    localparam logic [1:0] StNoDigits  = 2'd1;
    localparam logic [1:0] StOutOfRange = 2'd2;

    // character codes
    localparam logic [7:0] ChZero   = 8'h30;
    localparam logic [7:0] ChNine   = 8'h39;
    localparam logic [7:0] ChUpperA = 8'h41;
    localparam logic [7:0] ChUpperZ = 8'h5A;
    localparam logic [7:0] ChLowerA = 8'h61;
    localparam logic [7:0] ChLowerZ = 8'h7A;
    localparam logic [7:0] ChMinus  = 8'h2D;
    localparam logic [7:0] ChPlus   = 8'h2B;
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChUpperX = 8'h58;
    localparam logic [7:0] ChLowerX = 8'h78;
    localparam logic [7:0] NotDigit = 8'hFF;

    // default base values
    localparam logic [5:0] BaseOctal   = 6'd8;
    localparam logic [5:0] BaseDecimal = 6'd10;
    localparam logic [5:0] BaseHex     = 6'd16;
    localparam logic [5:0] BaseMin     = 6'd2;
    localparam logic [5:0] BaseMax     = 6'd36;

    typedef struct packed {
        logic [7:0] char_code;
        logic       start_req;
    } atoi_in_t;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
        logic [15:0] consumed_count;
    } atoi_out_t;

    // digit value of a character, all ones when it is no digit
    function automatic logic [7:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = NotDigit;
        if (c >= ChZero && c <= ChNine) begin
            d = c - ChZero;
        end else if (c >= ChUpperA && c <= ChUpperZ) begin
            d = c - ChUpperA + 8'd10;
        end else if (c >= ChLowerA && c <= ChLowerZ) begin
            d = c - ChLowerA + 8'd10;
        end
        return d;
    endfunction

    // largest magnitude allowed for the current mode and sign
    function automatic logic [63:0] mag_limit(input logic signed_mode,
                                              input logic narrow_mode,
                                              input logic negative);
        logic [63:0] half;
        logic [63:0] lim;
        half = narrow_mode ? 64'h0000_0000_8000_0000 : 64'h8000_0000_0000_0000;
        if (!signed_mode) begin
            lim = narrow_mode ? 64'h0000_0000_FFFF_FFFF : '1;
        end else begin
            lim = negative ? half : half - 64'd1;
        end
        return lim;
    endfunction

endpackage

[hdl/ascii_to_integer_parser.sv]
// ----------------------------------------------------------------------------
// ascii_to_integer_parser
// Converts a text, one character per transfer, into a 32 or 64 bit integer
// in the style of the C library string to integer conversions.
// ----------------------------------------------------------------------------
// The parser takes one character per clock cycle, but a character that ends
// a number waits while the output register still holds an untaken result.
// A character passes an input register, then combinational logic updates the
// accumulator with one multiply-add by the base and one compare against the
// limit, which is what sets the one character per cycle figure; the result
// is then held in an output register. Only the character that ends a number
// makes a result transfer; number_base is sampled at the first character that
// is not white space, signed_mode and narrow_mode are used as they stand.
module ascii_to_integer_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_idx,
    input  logic [5:0]           cfg_wdata,
    // characters in
    input  logic                 s_valid,
    output logic                 s_ready,
    input  atoi_pkg::atoi_in_t   s_data,
    // results out
    output logic                 m_valid,
    input  logic                 m_ready,
    output atoi_pkg::atoi_out_t  m_data
);

    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_FIRST  = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [atoi_pkg::CountWidth-1:0] CountMax = '1;

    // configuration registers
    logic [5:0] number_base_reg;
    logic       signed_mode_reg;
    logic       narrow_mode_reg;

    // input stage
    logic               s1_valid_reg;
    atoi_pkg::atoi_in_t s1_data_reg;

    // parse state
    logic [2:0]                     phase_reg, phase_next;
    logic                           neg_reg, neg_next;
    logic [5:0]                     base_reg, base_next;
    logic [63:0]                    acc_reg, acc_next;
    logic                           ds_reg, ds_next;
    logic                           ovf_reg, ovf_next;
    logic [atoi_pkg::CountWidth-1:0] pos_reg, pos_next;

    // output register
    logic                m_valid_reg;
    atoi_pkg::atoi_out_t m_data_reg, m_data_next;

    // effective state after an optional start request
    logic [2:0]                     e_phase;
    logic                           e_neg;
    logic [5:0]                     e_base;
    logic [63:0]                    e_acc;
    logic                           e_ds;
    logic                           e_ovf;
    logic [atoi_pkg::CountWidth-1:0] e_pos;

    logic [7:0]  ch;
    logic [7:0]  dig;
    logic [5:0]  cur_base;
    logic [2:0]  phase_sel;
    logic [5:0]  base_sel;
    logic        do_step;
    logic [5:0]  st_base;
    logic [63:0] st_acc;
    logic        st_ds;
    logic        step_ok;
    logic [69:0] prod;
    logic [69:0] sum;
    logic [63:0] lim;
    logic        emit;
    logic [63:0] res;
    logic        out_free;
    logic        s1_go;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_base_reg <= atoi_pkg::BaseDecimal;
            signed_mode_reg <= 1'b1;
            narrow_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_idx)
                atoi_pkg::RegNumberBase: number_base_reg <= cfg_wdata;
                atoi_pkg::RegSignedMode: signed_mode_reg <= cfg_wdata[0];
                atoi_pkg::RegNarrowMode: narrow_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // handshake
    assign out_free = !m_valid_reg || m_ready;
    assign s1_go    = s1_valid_reg && (out_free || !emit);
    assign s_ready  = !s1_valid_reg || s1_go;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            s1_data_reg <= s_data;
        end
    end

    // start request clears the parse state
    always_comb begin
        if (s1_data_reg.start_req) begin
            e_phase = PH_SPACE;
            e_neg   = 1'b0;
            e_base  = '0;
            e_acc   = '0;
            e_ds    = 1'b0;
            e_ovf   = 1'b0;
            e_pos   = '0;
        end else begin
            e_phase = phase_reg;
            e_neg   = neg_reg;
            e_base  = base_reg;
            e_acc   = acc_reg;
            e_ds    = ds_reg;
            e_ovf   = ovf_reg;
            e_pos   = pos_reg;
        end
    end

    assign ch       = s1_data_reg.char_code;
    assign dig      = atoi_pkg::digit_of(ch);
    assign cur_base = (e_phase == PH_SPACE) ? number_base_reg : e_base;

    // phase decode, selects the operands of the digit step
    always_comb begin
        phase_sel  = e_phase;
        neg_next   = e_neg;
        base_sel   = e_base;
        do_step    = 1'b0;
        st_base    = e_base;
        st_acc     = e_acc;
        st_ds      = e_ds;
        case (e_phase)
            PH_SPACE, PH_FIRST: begin
                if (e_phase == PH_SPACE && ch inside {atoi_pkg::ChSpace,
                                                     [atoi_pkg::ChTab:atoi_pkg::ChCr]}) begin
                    phase_sel = PH_SPACE;
                end else if (e_phase == PH_SPACE && ch == atoi_pkg::ChMinus) begin
                    base_sel  = cur_base;
                    neg_next  = 1'b1;
                    phase_sel = PH_FIRST;
                end else if (e_phase == PH_SPACE && ch == atoi_pkg::ChPlus) begin
                    base_sel  = cur_base;
                    phase_sel = PH_FIRST;
                end else if ((cur_base == '0 || cur_base == atoi_pkg::BaseHex) &&
                             ch == atoi_pkg::ChZero) begin
                    base_sel  = cur_base;
                    phase_sel = PH_ZERO;
                end else begin
                    do_step = 1'b1;
                    st_base = (cur_base == '0) ? atoi_pkg::BaseDecimal : cur_base;
                end
            end
            PH_ZERO: begin
                if (ch == atoi_pkg::ChUpperX || ch == atoi_pkg::ChLowerX) begin
                    base_sel  = atoi_pkg::BaseHex;
                    phase_sel = PH_DIGITS;
                end else begin
                    do_step = 1'b1;
                    st_base = (e_base == '0) ? atoi_pkg::BaseOctal : e_base;
                    st_acc  = '0;
                    st_ds   = 1'b1;
                end
            end
            PH_DIGITS: begin
                do_step = 1'b1;
            end
            default: ;
        endcase
    end

    // multiply-add by the base as six shifted partial products
    always_comb begin
        prod = '0;
        for (int i = 0; i < 6; i++) begin
            if (st_base[i]) begin
                prod = prod + (70'(st_acc) << i);
            end
        end
        sum = prod + 70'(dig);
    end

    assign lim     = atoi_pkg::mag_limit(signed_mode_reg, narrow_mode_reg, neg_next);
    assign step_ok = st_base >= atoi_pkg::BaseMin && st_base <= atoi_pkg::BaseMax &&
                     dig < 8'(st_base);
    assign emit    = do_step && !step_ok;

    // accumulator update and overflow detection
    always_comb begin
        phase_next = phase_sel;
        base_next  = base_sel;
        acc_next   = st_acc;
        ds_next    = st_ds;
        ovf_next   = e_ovf;
        if (do_step) begin
            base_next = st_base;
            if (!step_ok) begin
                phase_next = PH_DONE;
            end else begin
                phase_next = PH_DIGITS;
                if (!e_ovf) begin
                    ds_next = 1'b1;
                    if (sum > 70'(lim)) begin
                        ovf_next = 1'b1;
                    end else begin
                        acc_next = sum[63:0];
                    end
                end
            end
        end
        pos_next = (e_pos == CountMax) ? e_pos : e_pos + 1'b1;
    end

    // result formatting
    always_comb begin
        m_data_next.consumed_count = 16'(e_pos);
        if (!st_ds) begin
            res                        = '0;
            m_data_next.status         = atoi_pkg::StNoDigits;
            m_data_next.consumed_count = '0;
        end else if (e_ovf || st_acc > lim) begin
            res                = (signed_mode_reg && neg_next) ? 64'd0 - lim : lim;
            m_data_next.status = atoi_pkg::StOutOfRange;
        end else begin
            res                = neg_next ? 64'd0 - st_acc : st_acc;
            m_data_next.status = atoi_pkg::StConverted;
        end
        if (narrow_mode_reg) begin
            res[63:32] = (signed_mode_reg && res[31]) ? '1 : '0;
        end
        m_data_next.value = res;
    end

    // parse state registers, untouched once the number is done
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SPACE;
            neg_reg   <= 1'b0;
            base_reg  <= '0;
            acc_reg   <= '0;
            ds_reg    <= 1'b0;
            ovf_reg   <= 1'b0;
            pos_reg   <= '0;
        end else if (s1_go) begin
            if (e_phase == PH_DONE) begin
                phase_reg <= e_phase;
            end else begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                base_reg  <= base_next;
                acc_reg   <= acc_next;
                ds_reg    <= ds_next;
                ovf_reg   <= ovf_next;
                pos_reg   <= pos_next;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_go && emit && e_phase != PH_DONE) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go && emit && e_phase != PH_DONE) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a result without digits is zero with nothing consumed
    a_no_digits_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.status == atoi_pkg::StNoDigits |->
            m_data_reg.value == 64'd0 && m_data_reg.consumed_count == 16'd0)
        else $error("no-digit result carries a value or count");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg.status == atoi_pkg::StConverted ||
                        m_data_reg.status == atoi_pkg::StNoDigits ||
                        m_data_reg.status == atoi_pkg::StOutOfRange)
        else $error("undefined status code");

    // overflow can only be flagged after a digit was taken
    a_ovf_needs_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> ds_reg)
        else $error("overflow without digits");

    // unsigned narrow results are zero extended
    a_narrow_unsigned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && narrow_mode_reg && !signed_mode_reg |->
            m_data_reg.value[63:32] == 32'd0)
        else $error("narrow unsigned result not zero extended");

    // a finished parse emits nothing further without a start request
    a_done_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_go && phase_reg == PH_DONE && !s1_data_reg.start_req |=> !$rose(m_valid_reg))
        else $error("result after the parse had ended");

endmodule

[sim/ascii_to_integer_parser_tb.sv]
// ----------------------------------------------------------------------------
// ascii_to_integer_parser_tb
// Streams texts into the parser one character per transfer and predicts each
// result with a behavioral copy of the conversion: white space, sign, base
// prefixes, saturation and position counting. Runs several register settings
// under varying sender and receiver idling and checks every result field.
// ----------------------------------------------------------------------------
module ascii_to_integer_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit   = 1_000_000;
    localparam int SettleCycles = 8;
    localparam int PhaseChars   = 108;
    localparam int NumPhases    = 11;
    localparam int MaxReports   = 50;

    localparam logic [7:0] CaseBit     = 8'h20;
    localparam logic [7:0] CharLowest  = 8'h00;
    localparam logic [7:0] CharHighest = 8'hFF;

    typedef enum logic [2:0] {
        ScanSpace,
        ScanSign,
        ScanZero,
        ScanDigits,
        ScanDone
    } scan_t;

    // block ports
    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [1:0]          cfg_idx   = '0;
    logic [5:0]          cfg_wdata = '0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    atoi_pkg::atoi_in_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    atoi_pkg::atoi_out_t m_data;

    // stimulus and expected results
    atoi_pkg::atoi_in_t  pending_chars[$];
    atoi_pkg::atoi_out_t conversions_due[$];
    logic      start_next     = 1'b0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    logic      char_taken     = 1'b0;

    // bookkeeping
    int chars_queued    = 0;
    int chars_sent      = 0;
    int results_checked = 0;
    int error_count     = 0;
    int cycle_count     = 0;

    // register copies
    logic [5:0] base_reg   = atoi_pkg::BaseDecimal;
    logic       signed_reg = 1'b1;
    logic       narrow_reg = 1'b0;

    // parser state as predicted from the accepted characters
    scan_t                           scan_phase  = ScanSpace;
    logic                            minus_seen  = 1'b0;
    logic [5:0]                      radix       = '0;
    logic [63:0]                     magnitude   = '0;
    logic                            have_digits = 1'b0;
    logic                            saturated   = 1'b0;
    logic [atoi_pkg::CountWidth-1:0] char_pos    = '0;

    ascii_to_integer_parser DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #1 aclk = ~aclk;

    // value of a character as a digit, NotDigit for anything else
    function automatic logic [7:0] char_digit(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | CaseBit;
        if (c >= atoi_pkg::ChZero && c <= atoi_pkg::ChNine) begin
            return c - atoi_pkg::ChZero;
        end
        if (folded >= atoi_pkg::ChLowerA && folded <= atoi_pkg::ChLowerZ) begin
            return folded - atoi_pkg::ChLowerA + 8'd10;
        end
        return atoi_pkg::NotDigit;
    endfunction

    // largest magnitude for the live mode bits and a given sign
    function automatic logic [63:0] limit_for(input logic neg);
        logic [63:0] top;
        if (!signed_reg) begin
            return narrow_reg ? 64'h0000_0000_FFFF_FFFF : '1;
        end
        top = narrow_reg ? 64'h0000_0000_7FFF_FFFF : 64'h7FFF_FFFF_FFFF_FFFF;
        return top + {63'd0, neg};
    endfunction

    function automatic logic [7:0] to_char(input int d);
        if (d < 10) begin
            return atoi_pkg::ChZero + 8'(d);
        end
        return ($urandom_range(0, 1) ? atoi_pkg::ChUpperA : atoi_pkg::ChLowerA) + 8'(d - 10);
    endfunction

    task automatic clear_scan();
        scan_phase  = ScanSpace;
        minus_seen  = 1'b0;
        radix       = '0;
        magnitude   = '0;
        have_digits = 1'b0;
        saturated   = 1'b0;
        char_pos    = '0;
    endtask

    // the parse ends: queue the value, status and end position
    task automatic close_text();
        atoi_pkg::atoi_out_t res;
        logic [63:0]         lim;
        lim = limit_for(minus_seen);
        res.consumed_count = char_pos;
        if (!have_digits) begin
            res.value          = '0;
            res.status         = atoi_pkg::StNoDigits;
            res.consumed_count = '0;
        end else if (saturated || magnitude > lim) begin
            res.status = atoi_pkg::StOutOfRange;
            res.value  = (signed_reg && minus_seen) ? 64'd0 - lim : lim;
        end else begin
            res.status = atoi_pkg::StConverted;
            res.value  = minus_seen ? 64'd0 - magnitude : magnitude;
        end
        if (narrow_reg) begin
            res.value[63:32] = (signed_reg && res.value[31]) ? '1 : '0;
        end
        conversions_due.push_back(res);
        scan_phase = ScanDone;
    endtask

    // one multiply-add step, or the end of the number
    task automatic take_digit(input logic [7:0] c);
        logic [7:0]  d;
        logic [63:0] lim;
        logic [63:0] cut;
        logic [63:0] rem;
        d = char_digit(c);
        if (radix < atoi_pkg::BaseMin || radix > atoi_pkg::BaseMax || d >= radix) begin
            close_text();
            return;
        end
        scan_phase = ScanDigits;
        if (saturated) begin
            return;
        end
        lim = limit_for(minus_seen);
        cut = lim / radix;
        rem = lim % radix;
        have_digits = 1'b1;
        if (magnitude > cut || (magnitude == cut && d > rem)) begin
            saturated = 1'b1;
        end else begin
            magnitude = magnitude * radix + d;
        end
    endtask

    // first character after white space and sign
    task automatic take_first(input logic [7:0] c);
        if ((radix == 0 || radix == atoi_pkg::BaseHex) && c == atoi_pkg::ChZero) begin
            scan_phase = ScanZero;
            return;
        end
        if (radix == 0) begin
            radix = atoi_pkg::BaseDecimal;
        end
        take_digit(c);
    endtask

    task automatic parse_char(input atoi_pkg::atoi_in_t item);
        logic [7:0] c;
        c = item.char_code;
        if (item.start_req) begin
            clear_scan();
        end
        if (scan_phase == ScanDone) begin
            return;
        end
        case (scan_phase)
            ScanSpace: begin
                if (!(c == atoi_pkg::ChSpace ||
                      (c >= atoi_pkg::ChTab && c <= atoi_pkg::ChCr))) begin
                    radix = base_reg;
                    if (c == atoi_pkg::ChMinus) begin
                        minus_seen = 1'b1;
                        scan_phase = ScanSign;
                    end else if (c == atoi_pkg::ChPlus) begin
                        scan_phase = ScanSign;
                    end else begin
                        take_first(c);
                    end
                end
            end
            ScanSign: begin
                take_first(c);
            end
            ScanZero: begin
                if (c == atoi_pkg::ChLowerX || c == atoi_pkg::ChUpperX) begin
                    radix      = atoi_pkg::BaseHex;
                    scan_phase = ScanDigits;
                end else begin
                    if (radix == 0) begin
                        radix = atoi_pkg::BaseOctal;
                    end
                    have_digits = 1'b1;
                    magnitude   = '0;
                    take_digit(c);
                end
            end
            default: begin
                take_digit(c);
            end
        endcase
        if (char_pos != '1) begin
            char_pos = char_pos + 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        error_count++;
        if (error_count <= MaxReports) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    task automatic check_result(input atoi_pkg::atoi_out_t got);
        atoi_pkg::atoi_out_t want;
        results_checked++;
        if (conversions_due.size() == 0) begin
            error_count++;
            if (error_count <= MaxReports) begin
                $display("%0t ns: result with none expected, actual value %0h status %0d count %0d",
                         $time, got.value, got.status, got.consumed_count);
            end
            return;
        end
        want = conversions_due.pop_front();
        if (got.value !== want.value) begin
            report_mismatch("value", want.value, got.value);
        end
        if (got.status !== want.status) begin
            report_mismatch("status", 64'(want.status), 64'(got.status));
        end
        if (got.consumed_count !== want.consumed_count) begin
            report_mismatch("consumed_count", 64'(want.consumed_count),
                            64'(got.consumed_count));
        end
    endtask

    // sample both channels, predict accepted characters, check results
    always @(posedge aclk) begin
        char_taken = aresetn && s_valid && s_ready;
        if (char_taken) begin
            parse_char(s_data);
            chars_sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            check_result(m_data);
        end
    end

    // character driver and result back-pressure
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || char_taken)) begin
            if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_chars.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= aresetn && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, conversions_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic put_char(input logic [7:0] c);
        atoi_pkg::atoi_in_t item;
        item.char_code = c;
        item.start_req = start_next;
        pending_chars.push_back(item);
        start_next = 1'b0;
        chars_queued++;
    endtask

    task automatic add_text(input string txt, input logic fresh);
        start_next = fresh;
        for (int i = 0; i < txt.len(); i++) begin
            put_char(txt[i]);
        end
    endtask

    // hold the sender until every transfer is done and every result is back
    task automatic drain();
        while (pending_chars.size() != 0 || s_valid || conversions_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        case (idx)
            atoi_pkg::RegNumberBase: base_reg = data;
            atoi_pkg::RegSignedMode: signed_reg = data[0];
            default:                 narrow_reg = data[0];
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // register setting and idling pattern of each phase
    task automatic setup_phase(input int p);
        logic [5:0] b;
        logic       sg;
        logic       nw;
        int         si;
        int         rs;
        case (p)
            0: begin b = atoi_pkg::BaseHex;     sg = 1'b0; nw = 1'b1; si = 0;  rs = 0;  end
            1: begin b = 6'd0;                  sg = 1'b1; nw = 1'b0; si = 73; rs = 0;  end
            2: begin b = atoi_pkg::BaseDecimal; sg = 1'b1; nw = 1'b1; si = 0;  rs = 73; end
            3: begin b = 6'd0;                  sg = 1'b0; nw = 1'b1; si = 29; rs = 29; end
            4: begin b = atoi_pkg::BaseMax;     sg = 1'b1; nw = 1'b0; si = 73; rs = 0;  end
            5: begin b = atoi_pkg::BaseMin;     sg = 1'b0; nw = 1'b0; si = 0;  rs = 73; end
            6: begin b = atoi_pkg::BaseOctal;   sg = 1'b1; nw = 1'b1; si = 29; rs = 29; end
            7: begin b = 6'd1;                  sg = 1'b0; nw = 1'b1; si = 0;  rs = 0;  end
            8: begin b = 6'd63;                 sg = 1'b1; nw = 1'b0; si = 29; rs = 29; end
            9: begin b = 6'd37;                 sg = 1'b0; nw = 1'b0; si = 0;  rs = 73; end
            default: begin
                b  = 6'($urandom_range(0, 36));
                sg = 1'($urandom_range(0, 1));
                nw = 1'($urandom_range(0, 1));
                si = ($urandom_range(0, 1) == 0) ? 0 : 29;
                rs = ($urandom_range(0, 1) == 0) ? 73 : 29;
            end
        endcase
        write_reg(atoi_pkg::RegNumberBase, b);
        write_reg(atoi_pkg::RegSignedMode, {5'($urandom_range(0, 31)), sg});
        write_reg(atoi_pkg::RegNarrowMode, {5'($urandom_range(0, 31)), nw});
        send_idle_pct  = si;
        recv_stall_pct = rs;
    endtask

    // one random text: mostly well-formed numbers, some noise and broken ones
    task automatic gen_text();
        logic [7:0]  c;
        logic [7:0]  digs[$];
        logic [63:0] lim;
        logic [63:0] mag;
        logic        neg;
        logic        extra;
        int          eb;
        int          n;
        int          sel;
        start_next = 1'b1;
        if ($urandom_range(0, 99) < 12) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                put_char(8'($urandom_range(0, 255)));
            end
            return;
        end
        // leading white space
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        for (int i = 0; i < n; i++) begin
            put_char(($urandom_range(0, 3) == 0) ? atoi_pkg::ChSpace :
                     8'($urandom_range(atoi_pkg::ChTab, atoi_pkg::ChCr)));
        end
        // sign
        neg = 1'b0;
        sel = $urandom_range(0, 2);
        if (sel == 1) begin
            put_char(atoi_pkg::ChPlus);
        end else if (sel == 2) begin
            put_char(atoi_pkg::ChMinus);
            neg = 1'b1;
        end
        // prefix
        eb = base_reg;
        if ((base_reg == 0 || base_reg == atoi_pkg::BaseHex) && $urandom_range(0, 2) == 0) begin
            put_char(atoi_pkg::ChZero);
            put_char($urandom_range(0, 1) ? atoi_pkg::ChUpperX : atoi_pkg::ChLowerX);
            eb = atoi_pkg::BaseHex;
        end else if (base_reg == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                put_char(atoi_pkg::ChZero);
                eb = atoi_pkg::BaseOctal;
            end else begin
                eb = atoi_pkg::BaseDecimal;
            end
        end
        // body
        if (eb < atoi_pkg::BaseMin || eb > atoi_pkg::BaseMax) begin
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
                put_char(to_char($urandom_range(0, 35)));
            end
            eb = 0;
        end else if ($urandom_range(0, 9) != 0) begin
            lim = limit_for(neg);
            sel = $urandom_range(0, 7);
            case (sel)
                0:       mag = 64'($urandom_range(0, 999));
                1:       mag = lim;
                2:       mag = lim - 64'd1;
                3:       mag = lim + 64'd1;
                4:       mag = '0;
                default: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
            endcase
            // one more than the unsigned maximum needs an extra digit
            extra = (sel == 3 && lim == '1) || $urandom_range(0, 15) == 0;
            if (sel == 3 && lim == '1) begin
                mag = lim;
            end
            do begin
                digs.push_front(to_char(int'(mag % eb)));
                mag = mag / eb;
            end while (mag != 0);
            if (extra) begin
                digs.push_back(to_char($urandom_range(0, eb - 1)));
            end
            foreach (digs[i]) begin
                put_char(digs[i]);
            end
        end
        // terminator, sometimes left open; bytes after a result are ignored
        if ($urandom_range(0, 99) >= 8) begin
            do begin
                c = 8'($urandom_range(0, 255));
            end while (char_digit(c) < eb);
            put_char(c);
            if ($urandom_range(0, 3) == 0) begin
                put_char(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        int phase_start;
        clear_scan();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // bytes before any start request parse from the reset state
        add_text("42;", 1'b0);
        // all white space kinds, plus sign, lowest byte as terminator
        start_next = 1'b1;
        put_char(atoi_pkg::ChSpace);
        for (int c = atoi_pkg::ChTab; c <= atoi_pkg::ChCr; c++) begin
            put_char(8'(c));
        end
        add_text("+17", 1'b0);
        put_char(CharLowest);
        // sign with no digits, then bytes that must be ignored
        add_text("-;99", 1'b1);
        // a start request in the middle of a number restarts the parse
        add_text("12", 1'b1);
        add_text("5.", 1'b1);
        add_text("+-", 1'b1);
        add_text("7", 1'b1);
        put_char(CharHighest);
        // left open across the next register writes: base stays latched
        add_text(" -12", 1'b1);

        for (int p = 0; p < NumPhases; p++) begin
            drain();
            setup_phase(p);
            phase_start = chars_queued;
            if (p == 0) begin
                add_text("3z", 1'b0);
            end
            while (chars_queued - phase_start < PhaseChars) begin
                gen_text();
            end
        end
        drain();

        $display("Sent %0d characters under %0d register settings with varied idling",
                 chars_sent, NumPhases + 1);
        $display("Checked %0d results, %0d mismatches", results_checked, error_count);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/atoi_pkg.sv
hdl/ascii_to_integer_parser.sv
sim/ascii_to_integer_parser_tb.sv
